### rtl/core/nlhm_pkg.sv
// nlhm_pkg: shared types and constants of the link health monitor
// used by nlhm_cell, nlhm_sampler and network_link_health_monitor; no dependencies
`default_nettype none

package nlhm_pkg;

  // window bits held by one cell of the chain
  localparam int CELL_BITS = 8;

  // item kinds carried in tuser
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_FORCE = 1'b1;

  // link mode register values
  localparam logic MODE_ETH  = 1'b0;
  localparam logic MODE_CELL = 1'b1;

  // register indexes, taken from paddr[2]
  localparam logic REG_LINK_MODE  = 1'b0;
  localparam logic REG_WINDOW_LEN = 1'b1;

  // register reset values
  localparam logic       DEFAULT_LINK_MODE  = MODE_CELL;
  localparam logic [7:0] DEFAULT_WINDOW_LEN = 8'd20;

  // ethernet receive status codes
  localparam logic [1:0] ETH_ST_IDLE  = 2'd0;
  localparam logic [1:0] ETH_ST_DATA  = 2'd1;
  localparam logic [1:0] ETH_ST_FAULT = 2'd2;

  // cellular probe timing and retry limits
  localparam logic [3:0]  PROBE_LAST   = 4'd10;
  localparam logic [6:0]  RETRY_FIRST  = 7'd1;
  localparam logic [6:0]  RETRY_LIMIT  = 7'd90;
  localparam logic [15:0] RX_THRESHOLD = 16'd20;

  // ethernet fail counter periods, residues count up to these
  localparam logic [3:0] NOTIFY_LAST  = 4'd9;
  localparam logic [5:0] RESTART_LAST = 6'd59;
  localparam logic [7:0] FAIL_WRAP    = 8'hFF;

  // per-transfer control broadcast to every cell
  typedef struct packed {
    logic tick;
    logic force_all;
    logic sample;
  } cell_ctrl_t;

  // agreement carry passed from cell to cell
  typedef struct packed {
    logic all_one;
    logic all_zero;
  } agree_t;

  // raw sample and pulses from the link sampler
  typedef struct packed {
    logic sample;
    logic notify;
    logic restart;
    logic eth_ok;
  } smp_res_t;

endpackage

`default_nettype wire

### rtl/core/nlhm_cell.sv
// nlhm_cell: one cell of the sample window chain, holding CELL_BITS window bits
// depends on nlhm_pkg
`default_nettype none

module nlhm_cell
  import nlhm_pkg::*;
#(
  parameter int BASE = 0,
  parameter int LW   = 8,
  parameter int PW   = 7
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire cell_ctrl_t    ctrl,
  input  wire logic [PW-1:0] wpos,
  input  wire logic [LW-1:0] len,
  input  wire agree_t        agree_in,
  output agree_t             agree_out
);

  logic [CELL_BITS-1:0] win_r;
  logic [CELL_BITS-1:0] win_nxt;
  logic [CELL_BITS-1:0] act;
  logic [CELL_BITS-1:0] hit;
  logic [CELL_BITS-1:0] win_new;

  always_comb begin
    for (int k = 0; k < CELL_BITS; k++) begin
      act[k]     = ((BASE + k) < int'(len));
      hit[k]     = ((BASE + k) == int'(wpos));
      win_new[k] = hit[k] ? ctrl.sample : win_r[k];
    end
  end

  always_comb begin
    win_nxt = win_r;
    if (ctrl.force_all) begin
      win_nxt = win_r | act;
    end else if (ctrl.tick) begin
      win_nxt = win_new;
    end
  end

  // inactive bits never block agreement
  assign agree_out.all_one  = agree_in.all_one  & (&(win_new | ~act));
  assign agree_out.all_zero = agree_in.all_zero & (&(~win_new | ~act));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '1;
    end else begin
      win_r <= win_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/nlhm_sampler.sv
// nlhm_sampler: raw fault sample, receive notify and restart pulses per tick
// depends on nlhm_pkg
`default_nettype none

module nlhm_sampler
  import nlhm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        tick,
  input  wire logic        link_mode,
  input  wire logic        modem_ready,
  input  wire logic        modem_probe_failed,
  input  wire logic [15:0] modem_rx_bytes,
  input  wire logic        eth_ready,
  input  wire logic [1:0]  eth_status,
  output smp_res_t         res
);

  logic [3:0] ptc_r, ptc_nxt;
  logic       lpf_r, lpf_nxt;
  logic       cf_r, cf_nxt;
  logic [6:0] rrc_r, rrc_nxt;
  logic [6:0] rrc_inc;
  logic [7:0] efc_r, efc_nxt;
  logic [3:0] r10_r, r10_nxt;
  logic [5:0] r60_r, r60_nxt;
  logic       eok_r, eok_nxt;
  logic [1:0] status;

  assign rrc_inc = rrc_r + 7'd1;
  // controller not ready counts as a fault status
  assign status  = eth_ready ? eth_status : ETH_ST_FAULT;

  always_comb begin
    ptc_nxt     = ptc_r;
    lpf_nxt     = lpf_r;
    cf_nxt      = cf_r;
    rrc_nxt     = rrc_r;
    efc_nxt     = efc_r;
    r10_nxt     = r10_r;
    r60_nxt     = r60_r;
    eok_nxt     = eok_r;
    res.sample  = 1'b0;
    res.notify  = 1'b0;
    res.restart = 1'b0;
    if (tick) begin
      if (link_mode == MODE_CELL) begin
        if (modem_ready) begin
          if (ptc_r >= PROBE_LAST) begin
            ptc_nxt = '0;
            if (lpf_r && modem_probe_failed) begin
              if (rrc_inc == RETRY_FIRST || rrc_inc == RETRY_LIMIT) begin
                res.restart = 1'b1;
              end
              rrc_nxt = (rrc_inc >= RETRY_LIMIT) ? '0 : rrc_inc;
              cf_nxt  = 1'b1;
            end else begin
              cf_nxt = 1'b0;
            end
            lpf_nxt = modem_probe_failed;
          end else begin
            ptc_nxt = ptc_r + 4'd1;
          end
          if (modem_rx_bytes > RX_THRESHOLD) begin
            res.notify = 1'b1;
          end
        end
        res.sample = cf_nxt;
      end else begin
        case (status)
          ETH_ST_DATA: begin
            eok_nxt    = 1'b1;
            efc_nxt    = '0;
            r10_nxt    = '0;
            r60_nxt    = '0;
            res.notify = 1'b1;
          end
          ETH_ST_IDLE: begin
            eok_nxt = 1'b1;
            efc_nxt = '0;
            r10_nxt = '0;
            r60_nxt = '0;
          end
          default: begin
            eok_nxt    = 1'b0;
            res.sample = 1'b1;
            efc_nxt    = efc_r + 8'd1;
            // counter wrap to zero is a multiple of both periods
            if (efc_r == FAIL_WRAP) begin
              r10_nxt = '0;
              r60_nxt = '0;
            end else begin
              r10_nxt = (r10_r == NOTIFY_LAST) ? '0 : r10_r + 4'd1;
              r60_nxt = (r60_r == RESTART_LAST) ? '0 : r60_r + 6'd1;
            end
            res.notify  = (r10_nxt == '0);
            res.restart = (r60_nxt == '0);
          end
        endcase
      end
    end
    res.eth_ok = eok_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptc_r <= '0;
      lpf_r <= 1'b1;
      cf_r  <= 1'b1;
      rrc_r <= '0;
      efc_r <= '0;
      r10_r <= '0;
      r60_r <= '0;
      eok_r <= 1'b0;
    end else begin
      ptc_r <= ptc_nxt;
      lpf_r <= lpf_nxt;
      cf_r  <= cf_nxt;
      rrc_r <= rrc_nxt;
      efc_r <= efc_nxt;
      r10_r <= r10_nxt;
      r60_r <= r60_nxt;
      eok_r <= eok_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/network_link_health_monitor.sv
// network_link_health_monitor: debounced link fault monitor, top level
// each result is registered into out_data_r, or into the skid entry while the output is stalled
// throughput: one item per cycle while the skid entry is empty, set by the agreement chain through the window cells
// a two-entry output stage keeps in_tready high while one finished result waits
// reset: synchronous active-low rst_n; window reads as fault, debounced fault clear
// registers come up as link_mode cellular and window_length 20
`default_nettype none

module network_link_health_monitor
  import nlhm_pkg::*;
#(
  parameter int WINDOW_DEPTH = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [0] modem_ready, [1] modem_probe_failed, [17:2] modem_rx_bytes,
  // [18] eth_ready, [20:19] eth_status, [23:21] zero
  input  wire logic [23:0] in_tdata,
  // [0] kind
  input  wire logic        in_tuser,
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [0] link_fault, [1] notify_receive, [2] request_restart, [3] eth_link_ok,
  // [7:4] zero
  output logic [7:0]       out_tdata,
  // configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  // position and length widths follow the window depth
  localparam int PW        = $clog2(WINDOW_DEPTH);
  localparam int LW        = $clog2(WINDOW_DEPTH + 1);
  localparam int NUM_CELLS = (WINDOW_DEPTH + CELL_BITS - 1) / CELL_BITS;
  localparam logic [8:0] DEPTH9 = 9'(WINDOW_DEPTH);

  typedef struct packed {
    logic eth_link_ok;
    logic request_restart;
    logic notify_receive;
    logic link_fault;
  } out_res_t;

  // active window length: zero means one, anything above the depth saturates
  function automatic logic [LW-1:0] clamp_len(input logic [7:0] wl);
    logic [8:0] wl9;
    logic [8:0] len9;
    wl9 = {1'b0, wl};
    if (wl9 == 9'd0) begin
      len9 = 9'd1;
    end else if (wl9 > DEPTH9) begin
      len9 = DEPTH9;
    end else begin
      len9 = wl9;
    end
    return len9[LW-1:0];
  endfunction

  // write position after one advance, wrapping at the active length
  function automatic logic [PW-1:0] next_pos(input logic [PW-1:0] p,
                                             input logic [LW-1:0] n);
    logic [LW-1:0] p1;
    p1 = LW'(p) + LW'(1);
    return (p1 >= n) ? '0 : p1[PW-1:0];
  endfunction

  // configuration registers
  logic          mode_r;
  logic [7:0]    wl_r;
  logic          cfg_wr;
  logic [LW-1:0] len_cur;

  // window pointer: wp_r is the last written slot, np_r the slot of the next tick
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] np_r, np_nxt;

  logic          deb_r, deb_nxt;

  logic          in_fire;
  logic          out_fire;
  logic          tick;
  logic          force_all;

  smp_res_t      smp;
  cell_ctrl_t    ctrl;
  agree_t        chain [NUM_CELLS+1];
  logic          agree;

  out_res_t      res;
  out_res_t      out_data_r;
  out_res_t      skid_data_r;
  logic          out_v_r;
  logic          skid_v_r;

  // ------------------------------------------------------------------
  // configuration port, always ready, written on the access cycle
  // ------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_WINDOW_LEN) ? {24'd0, wl_r} : {31'd0, mode_r};
  assign len_cur    = clamp_len(wl_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= DEFAULT_LINK_MODE;
      wl_r   <= DEFAULT_WINDOW_LEN;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_WINDOW_LEN) begin
        wl_r <= cfg_pwdata[7:0];
      end else begin
        mode_r <= cfg_pwdata[0];
      end
    end
  end

  // ------------------------------------------------------------------
  // input transfer decode
  // ------------------------------------------------------------------
  assign in_tready = ~skid_v_r;
  assign in_fire   = in_tvalid & in_tready;
  assign out_fire  = out_tvalid & out_tready;
  assign tick      = in_fire & (in_tuser == KIND_TICK);
  assign force_all = in_fire & (in_tuser == KIND_FORCE);

  // ------------------------------------------------------------------
  // raw sample for the selected link mode
  // ------------------------------------------------------------------
  nlhm_sampler u_sampler (
    .clk                (clk),
    .rst_n              (rst_n),
    .tick               (tick),
    .link_mode          (mode_r),
    .modem_ready        (in_tdata[0]),
    .modem_probe_failed (in_tdata[1]),
    .modem_rx_bytes     (in_tdata[17:2]),
    .eth_ready          (in_tdata[18]),
    .eth_status         (in_tdata[20:19]),
    .res                (smp)
  );

  // ------------------------------------------------------------------
  // sample window as a chain of cells; the agreement carry ripples
  // from cell to cell, each cell folding in its own bits with the
  // new sample already written at the next slot
  // ------------------------------------------------------------------
  assign ctrl.tick      = tick;
  assign ctrl.force_all = force_all;
  assign ctrl.sample    = smp.sample;

  assign chain[0].all_one  = 1'b1;
  assign chain[0].all_zero = 1'b1;

  for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
    nlhm_cell #(
      .BASE (c * CELL_BITS),
      .LW   (LW),
      .PW   (PW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .wpos      (np_r),
      .len       (len_cur),
      .agree_in  (chain[c]),
      .agree_out (chain[c+1])
    );
  end

  assign agree = smp.sample ? chain[NUM_CELLS].all_one : chain[NUM_CELLS].all_zero;

  // pointer advance on a tick; a length write re-aims the next slot
  always_comb begin
    wp_nxt  = wp_r;
    np_nxt  = np_r;
    deb_nxt = deb_r;
    if (tick) begin
      wp_nxt = np_r;
      np_nxt = next_pos(np_r, len_cur);
      if (agree) begin
        deb_nxt = smp.sample;
      end
    end else if (cfg_wr && cfg_paddr[2] == REG_WINDOW_LEN) begin
      np_nxt = next_pos(wp_r, clamp_len(cfg_pwdata[7:0]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      np_r  <= next_pos('0, clamp_len(DEFAULT_WINDOW_LEN));
      deb_r <= 1'b0;
    end else begin
      wp_r  <= wp_nxt;
      np_r  <= np_nxt;
      deb_r <= deb_nxt;
    end
  end

  // ------------------------------------------------------------------
  // result and two-entry output stage; a force item gives no pulses
  // ------------------------------------------------------------------
  assign res.link_fault      = deb_nxt;
  assign res.notify_receive  = tick & smp.notify;
  assign res.request_restart = tick & smp.restart;
  assign res.eth_link_ok     = smp.eth_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (in_fire) begin
        if (out_v_r && !out_tready) begin
          skid_v_r <= 1'b1;
        end else begin
          out_v_r <= 1'b1;
        end
      end else if (out_fire) begin
        if (skid_v_r) begin
          skid_v_r <= 1'b0;
        end else begin
          out_v_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (out_v_r && !out_tready) begin
        skid_data_r <= res;
      end else begin
        out_data_r <= res;
      end
    end else if (out_fire && skid_v_r) begin
      out_data_r <= skid_data_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {4'd0, out_data_r};

endmodule

`default_nettype wire

### tb/link_health_check_pkg.sv
// link_health_check_pkg: fault predictor and result scoreboard for the link health monitor bench
// depends on nlhm_pkg for item kinds, link modes, register indexes and status codes
package link_health_check_pkg;
  import nlhm_pkg::*;

  localparam int         WIN_SLOTS          = 128;
  localparam logic [1:0] ETH_ST_BAD         = 2'd3;
  localparam int         FAIL_NOTIFY_EVERY  = 10;
  localparam int         FAIL_RESTART_EVERY = 60;

  typedef struct packed {
    logic link_fault;
    logic notify;
    logic restart;
    logic eth_ok;
  } link_status_t;

  class link_health_scoreboard;
    // register copies
    logic         link_mode;
    logic [7:0]   window_len;
    // predicted block state
    logic         window_bits [WIN_SLOTS];
    int           wr_pos;
    logic         deb_fault;
    logic [3:0]   probe_ticks;
    logic         last_probe_bad;
    logic         cell_fault;
    int           retry_count;
    logic [7:0]   eth_fails;
    logic         eth_ok;
    link_status_t expected_status [$];
    int           fail_count;
    int           items_seen;
    int           force_seen;
    int           results_checked;
    int           notify_seen;
    int           restart_seen;

    function new();
      fail_count      = 0;
      items_seen      = 0;
      force_seen      = 0;
      results_checked = 0;
      notify_seen     = 0;
      restart_seen    = 0;
      link_mode       = DEFAULT_LINK_MODE;
      window_len      = DEFAULT_WINDOW_LEN;
      foreach (window_bits[i]) window_bits[i] = 1'b1;
      wr_pos          = 0;
      deb_fault       = 1'b0;
      probe_ticks     = 4'd0;
      last_probe_bad  = 1'b1;
      cell_fault      = 1'b1;
      retry_count     = 0;
      eth_fails       = 8'd0;
      eth_ok          = 1'b0;
    endfunction

    function void set_reg(logic idx, logic [31:0] value);
      if (idx == REG_LINK_MODE) link_mode = value[0];
      else window_len = value[7:0];
    endfunction

    function int active_len();
      int n;
      n = window_len;
      if (n == 0) n = 1;
      if (n > WIN_SLOTS) n = WIN_SLOTS;
      return n;
    endfunction

    function int outstanding();
      return expected_status.size();
    endfunction

    task note_failure(string msg);
      $display("mismatch: %s", msg);
      fail_count++;
    endtask

    // works out the result of one accepted item and queues it
    function void note_item(logic kind, logic [23:0] d);
      int           len;
      logic         ready;
      logic         probe_bad;
      logic [15:0]  rx;
      logic [1:0]   st;
      logic         smp;
      logic         agree;
      link_status_t r;
      len       = active_len();
      ready     = d[0];
      probe_bad = d[1];
      rx        = d[17:2];
      st        = d[18] ? d[20:19] : ETH_ST_BAD;
      smp       = 1'b0;
      agree     = 1'b1;
      r         = '0;
      items_seen++;
      if (kind == KIND_FORCE) begin
        force_seen++;
        for (int i = 0; i < len; i++) window_bits[i] = 1'b1;
      end else begin
        wr_pos++;
        if (wr_pos >= len) wr_pos = 0;
        if (link_mode == MODE_CELL) begin
          if (ready) begin
            probe_ticks = probe_ticks + 4'd1;
            if (probe_ticks > PROBE_LAST) begin
              probe_ticks = 4'd0;
              if (last_probe_bad && probe_bad) begin
                retry_count++;
                if (retry_count == RETRY_FIRST || retry_count == RETRY_LIMIT) r.restart = 1'b1;
                if (retry_count >= RETRY_LIMIT) retry_count = 0;
                cell_fault = 1'b1;
              end else begin
                cell_fault = 1'b0;
              end
              last_probe_bad = probe_bad;
            end
            if (rx > RX_THRESHOLD) r.notify = 1'b1;
          end
          smp = cell_fault;
        end else begin
          case (st)
            ETH_ST_DATA: begin
              eth_ok    = 1'b1;
              eth_fails = 8'd0;
              r.notify  = 1'b1;
            end
            ETH_ST_IDLE: begin
              eth_ok    = 1'b1;
              eth_fails = 8'd0;
            end
            default: begin
              eth_ok    = 1'b0;
              smp       = 1'b1;
              eth_fails = eth_fails + 8'd1;
              if (eth_fails % FAIL_NOTIFY_EVERY == 0) r.notify = 1'b1;
              if (eth_fails % FAIL_RESTART_EVERY == 0) r.restart = 1'b1;
            end
          endcase
        end
        window_bits[wr_pos] = smp;
        for (int i = 0; i < len; i++) begin
          if (window_bits[i] != smp) agree = 1'b0;
        end
        if (agree) deb_fault = smp;
      end
      r.link_fault = deb_fault;
      r.eth_ok     = eth_ok;
      expected_status.push_back(r);
    endfunction

    task check_result(logic [7:0] d);
      link_status_t want;
      if (expected_status.size() == 0) begin
        note_failure($sformatf("result %02h arrived with nothing outstanding", d));
        return;
      end
      want = expected_status.pop_front();
      results_checked++;
      if (d[1]) notify_seen++;
      if (d[2]) restart_seen++;
      if (d[0] !== want.link_fault)
        note_failure($sformatf("result %0d link_fault %b, want %b",
                               results_checked, d[0], want.link_fault));
      if (d[1] !== want.notify)
        note_failure($sformatf("result %0d notify_receive %b, want %b",
                               results_checked, d[1], want.notify));
      if (d[2] !== want.restart)
        note_failure($sformatf("result %0d request_restart %b, want %b",
                               results_checked, d[2], want.restart));
      if (d[3] !== want.eth_ok)
        note_failure($sformatf("result %0d eth_link_ok %b, want %b",
                               results_checked, d[3], want.eth_ok));
    endtask
  endclass

endpackage

### tb/tb_top.sv
// tb_top: self-checking bench for network_link_health_monitor
// drives the input stream and config port, predicts every result via link_health_check_pkg
// depends on nlhm_pkg and the monitor rtl
module tb_top;
  import nlhm_pkg::*;
  import link_health_check_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  link_health_scoreboard sb;
  int cfg_writes = 0;
  // per-phase switches for random gaps on either side
  bit in_idle_on  = 1'b1;
  bit out_idle_on = 1'b1;
  // receive buffer sizes around the notify threshold
  logic [15:0] rx_edges [4];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  network_link_health_monitor dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // transfer monitor: pre-edge values, input noted before the result is checked
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_item(in_tuser, in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // result side back-pressure, a fresh stall drawn at random before each transfer
  initial begin : result_sink
    int stall;
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = out_idle_on ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!(out_tvalid && out_tready)) @(posedge clk);
    end
  end

  // fields from the lowest bit up, top three bits stay zero
  function automatic logic [23:0] pack_item(logic ready, logic probe, logic [15:0] rx,
                                            logic erdy, logic [1:0] st);
    return {3'b000, st, erdy, rx, probe, ready};
  endfunction

  // one input transfer after a random gap; tvalid left high for a back-to-back item
  task automatic send_item(input logic kind, input logic [23:0] payload);
    int gap;
    gap = in_idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= payload;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // register write: setup cycle, access cycle, then a return to idle
  task automatic write_reg(input logic idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    sb.set_reg(idx, value);
    cfg_writes++;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic read_reg(input logic idx, output logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    value = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // stop sending and let every outstanding result come back, after first waiting until the
  // monitor has noted the last input transfer
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // registers change only with the block idle; read back both afterwards
  task automatic set_mode(input logic mode, input logic [7:0] len);
    logic [31:0] rd;
    drain_results();
    write_reg(REG_LINK_MODE, {31'd0, mode});
    write_reg(REG_WINDOW_LEN, {24'd0, len});
    read_reg(REG_LINK_MODE, rd);
    if (rd[0] !== mode)
      sb.note_failure($sformatf("link_mode reads %b, written %b", rd[0], mode));
    read_reg(REG_WINDOW_LEN, rd);
    if (rd[7:0] !== len)
      sb.note_failure($sformatf("window_length reads %0d, written %0d", rd[7:0], len));
  endtask

  // random phase; the lean toggles between fault-heavy and healthy stretches so the
  // window gets runs long enough to agree; a locked phase keeps the link failing
  // to push the retry and fail counters along
  task automatic run_phase(input logic mode, input logic [7:0] len, input int count,
                           input bit locked);
    int          k;
    int          span;
    logic        kind;
    logic        lean;
    logic        ready;
    logic        probe;
    logic        erdy;
    logic [15:0] rx;
    logic [1:0]  st;
    set_mode(mode, len);
    in_idle_on  = ($urandom_range(0, 3) != 0);
    out_idle_on = ($urandom_range(0, 3) != 0);
    span = (len == 0) ? 1 : ((len > 128) ? 128 : len);
    lean = locked ? 1'b1 : 1'($urandom_range(0, 1));
    for (k = 0; k < count; k++) begin
      if (!locked && $urandom_range(0, span + 8) == 0) lean = ~lean;
      kind  = ($urandom_range(0, 19) == 0) ? KIND_FORCE : KIND_TICK;
      ready = locked ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 4) != 0);
      if (locked) probe = 1'b1;
      else if (lean) probe = ($urandom_range(0, 7) != 0);
      else probe = ($urandom_range(0, 7) == 0);
      rx = $urandom_range(0, 1) ? 16'($urandom_range(0, 40)) : 16'($urandom_range(0, 65535));
      if (lean) erdy = locked ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 3) != 0);
      else erdy = ($urandom_range(0, 15) != 0);
      if (lean) begin
        if (!locked && $urandom_range(0, 9) == 0) st = ETH_ST_IDLE;
        else st = ($urandom_range(0, 3) == 0) ? ETH_ST_BAD : ETH_ST_FAULT;
      end else begin
        if ($urandom_range(0, 9) == 0) st = ETH_ST_FAULT;
        else st = ($urandom_range(0, 1) == 0) ? ETH_ST_DATA : ETH_ST_IDLE;
      end
      send_item(kind, pack_item(ready, probe, rx, erdy, st));
    end
  endtask

  initial begin : stimulus
    int k;
    sb = new();
    rx_edges[0] = 16'd0;
    rx_edges[1] = RX_THRESHOLD;
    rx_edges[2] = RX_THRESHOLD + 16'd1;
    rx_edges[3] = 16'hFFFF;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= KIND_TICK;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset registers: cellular mode with a window of 20
    // force item with every field bit set
    send_item(KIND_FORCE, 24'h1F_FFFF);
    // modem not ready: probe counter held, no notify even with a full buffer
    send_item(KIND_TICK, pack_item(1'b0, 1'b1, 16'hFFFF, 1'b1, ETH_ST_FAULT));
    // eleven ready ticks reach the first probe; a failed probe after the reset
    // failure is the first retry, which asks for a restart
    for (k = 0; k < 11; k++)
      send_item(KIND_TICK, pack_item(1'b1, 1'b1, rx_edges[k % 4], 1'b0, ETH_ST_IDLE));
    send_item(KIND_FORCE, pack_item(1'b1, 1'b0, 16'd0, 1'b0, ETH_ST_IDLE));

    // directed ethernet, single-entry window so the fault follows each sample
    set_mode(MODE_ETH, 8'd1);
    send_item(KIND_TICK, pack_item(1'b0, 1'b0, 16'd0, 1'b1, ETH_ST_IDLE));
    send_item(KIND_TICK, pack_item(1'b1, 1'b1, 16'hFFFF, 1'b1, ETH_ST_DATA));
    send_item(KIND_TICK, pack_item(1'b0, 1'b0, 16'd0, 1'b1, ETH_ST_FAULT));
    // status code three counts as a fault
    send_item(KIND_TICK, pack_item(1'b1, 1'b0, 16'd0, 1'b1, ETH_ST_BAD));
    // controller not ready overrides an idle status
    send_item(KIND_TICK, pack_item(1'b0, 1'b1, 16'd0, 1'b0, ETH_ST_IDLE));
    send_item(KIND_FORCE, pack_item(1'b0, 1'b0, 16'd0, 1'b1, ETH_ST_IDLE));

    // random phases across both modes and window lengths at and beyond the limits;
    // a short window after a long one leaves the write position past the end
    run_phase(MODE_CELL, 8'd20, 40, 1'b0);
    run_phase(MODE_ETH, 8'd1, 30, 1'b0);
    run_phase(MODE_ETH, 8'd128, 50, 1'b0);
    run_phase(MODE_ETH, 8'd3, 20, 1'b0);
    run_phase(MODE_CELL, 8'd0, 20, 1'b0);
    run_phase(MODE_ETH, 8'd255, 30, 1'b0);
    // unbroken ethernet failures: fail counter passes 256 and wraps
    run_phase(MODE_ETH, 8'd6, 280, 1'b1);
    run_phase(MODE_CELL, 8'd2, 20, 1'b0);
    // unbroken probe failures: repeated retries with the fault held
    run_phase(MODE_CELL, 8'd40, 40, 1'b1);
    run_phase(MODE_ETH, 8'd12, 30, 1'b0);
    run_phase(MODE_CELL, 8'd5, 30, 1'b0);

    drain_results();
    repeat (4) @(posedge clk);
    $display("summary: %0d items sent (%0d forced), %0d results checked, %0d register writes",
             sb.items_seen, sb.force_seen, sb.results_checked, cfg_writes);
    $display("summary: %0d receive notifies and %0d restart requests seen, %0d mismatches",
             sb.notify_seen, sb.restart_seen, sb.fail_count);
    if (sb.fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog well beyond the slowest legal run
  initial begin : watchdog
    #2000000;
    $display("timeout: %0d results still outstanding", sb.outstanding());
    $display("status: fail");
    $finish;
  end

endmodule
